// ===== hw/rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, codes and layout constants shared by the payload frame checker.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int SEED_BYTES  = 32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [3:0]  field_kind;
        logic [9:0]  entry_index;
        logic        field_complete;
        logic [63:0] field_value;
        logic [1:0]  message_type;
        logic        message_end;
        logic [2:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  version_code;
        logic [7:0]  roster_type_code;
        logic [7:0]  case_open_type_code;
        logic [7:0]  result_type_code;
        logic [7:0]  add_op_code;
        logic [7:0]  remove_op_code;
        logic [15:0] max_id_length;
        logic [10:0] entry_capacity;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_VERSION   = 3'd0,
        REG_ROSTER    = 3'd1,
        REG_CASE_OPEN = 3'd2,
        REG_RESULT    = 3'd3,
        REG_ADD_OP    = 3'd4,
        REG_REMOVE_OP = 3'd5,
        REG_MAX_IDLEN = 3'd6,
        REG_CAPACITY  = 3'd7
    } cfg_idx_t;

    typedef enum logic [15:0] {
        PH_VER    = 16'h0001,
        PH_TYPE   = 16'h0002,
        PH_OP     = 16'h0004,
        PH_COUNT  = 16'h0008,
        PH_CIDLEN = 16'h0010,
        PH_CID    = 16'h0020,
        PH_CUTOFF = 16'h0040,
        PH_DRAW   = 16'h0080,
        PH_SEED   = 16'h0100,
        PH_ALGO   = 16'h0200,
        PH_PRIM   = 16'h0400,
        PH_ALT    = 16'h0800,
        PH_IDLEN  = 16'h1000,
        PH_ID     = 16'h2000,
        PH_DONE   = 16'h4000,
        PH_DRAIN  = 16'h8000
    } phase_t;

    localparam logic [3:0] KIND_VERSION   = 4'd0;
    localparam logic [3:0] KIND_TYPE      = 4'd1;
    localparam logic [3:0] KIND_OP        = 4'd2;
    localparam logic [3:0] KIND_COUNT     = 4'd3;
    localparam logic [3:0] KIND_CIDLEN    = 4'd4;
    localparam logic [3:0] KIND_CID       = 4'd5;
    localparam logic [3:0] KIND_CUTOFF    = 4'd6;
    localparam logic [3:0] KIND_DRAW      = 4'd7;
    localparam logic [3:0] KIND_SEED      = 4'd8;
    localparam logic [3:0] KIND_ALGO      = 4'd9;
    localparam logic [3:0] KIND_PRIMARY   = 4'd10;
    localparam logic [3:0] KIND_ALTERNATE = 4'd11;
    localparam logic [3:0] KIND_IDLEN     = 4'd12;
    localparam logic [3:0] KIND_ID        = 4'd13;
    localparam logic [3:0] KIND_IGNORED   = 4'd14;

    localparam logic [1:0] MSG_UNKNOWN = 2'd0;
    localparam logic [1:0] MSG_ROSTER  = 2'd1;
    localparam logic [1:0] MSG_CASE    = 2'd2;
    localparam logic [1:0] MSG_RESULT  = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_VERSION = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd2;
    localparam logic [2:0] ST_BAD_OP      = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT   = 3'd4;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd5;
    localparam logic [2:0] ST_TRUNCATED   = 3'd6;
    localparam logic [2:0] ST_TRAILING    = 3'd7;

    function automatic logic [3:0] phase_kind(input phase_t ph);
        logic [3:0] k;
        case (ph)
            PH_VER:    k = KIND_VERSION;
            PH_TYPE:   k = KIND_TYPE;
            PH_OP:     k = KIND_OP;
            PH_COUNT:  k = KIND_COUNT;
            PH_CIDLEN: k = KIND_CIDLEN;
            PH_CID:    k = KIND_CID;
            PH_CUTOFF: k = KIND_CUTOFF;
            PH_DRAW:   k = KIND_DRAW;
            PH_SEED:   k = KIND_SEED;
            PH_ALGO:   k = KIND_ALGO;
            PH_PRIM:   k = KIND_PRIMARY;
            PH_ALT:    k = KIND_ALTERNATE;
            PH_IDLEN:  k = KIND_IDLEN;
            PH_ID:     k = KIND_ID;
            default:   k = KIND_IGNORED;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] field_size(input phase_t ph);
        logic [15:0] s;
        case (ph)
            PH_COUNT, PH_CIDLEN, PH_IDLEN: s = 16'd2;
            PH_CUTOFF, PH_DRAW:            s = 16'd8;
            PH_PRIM, PH_ALT:               s = 16'd4;
            PH_SEED:                       s = 16'(SEED_BYTES);
            default:                       s = 16'd1;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/pfc_parser.sv =====
// ----------------------------------------------------------------------------
// pfc_parser
// Phase machine and field counters; labels one byte per advance cycle.
// ----------------------------------------------------------------------------
module pfc_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  pfc_pkg::cfg_t       cfg,
    input  pfc_pkg::in_item_t   in_item,
    output pfc_pkg::out_item_t  result
);

    pfc_pkg::phase_t phase_reg, phase_next;
    logic [15:0] left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  msg_reg, msg_next;
    logic [10:0] entries_reg, entries_next;
    logic [9:0]  entry_reg, entry_next;
    logic [31:0] prim_reg, prim_next;
    logic [2:0]  err_reg, err_next;

    always_comb begin
        logic [63:0] acc_shift;
        logic [15:0] left_dec;
        logic [15:0] v16;
        logic [31:0] v32;
        logic [31:0] alt_room;
        logic [15:0] total;
        logic [10:0] entries_dec;
        logic        do_fail;
        logic [2:0]  fail_code;
        logic        do_enter;
        pfc_pkg::phase_t enter_phase;
        logic [15:0] enter_size;
        logic        use_size;

        phase_next   = phase_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        msg_next     = msg_reg;
        entries_next = entries_reg;
        entry_next   = entry_reg;
        prim_next    = prim_reg;
        err_next     = err_reg;

        acc_shift   = {acc_reg[55:0], in_item.data_byte};
        left_dec    = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;
        v16         = acc_shift[15:0];
        v32         = acc_shift[31:0];
        alt_room    = 32'(pfc_pkg::MAX_ENTRIES) - prim_reg;
        total       = prim_reg[15:0] + v32[15:0];
        entries_dec = entries_reg - 11'd1;
        do_fail     = 1'b0;
        fail_code   = pfc_pkg::ST_OK;
        do_enter    = 1'b0;
        enter_phase = pfc_pkg::PH_VER;
        enter_size  = 16'd1;
        use_size    = 1'b0;

        result.byte_value     = in_item.data_byte;
        result.field_kind     = pfc_pkg::KIND_IGNORED;
        result.entry_index    = 10'd0;
        result.field_complete = 1'b0;
        result.field_value    = 64'd0;

        if (phase_reg == pfc_pkg::PH_DONE) begin
            do_fail   = 1'b1;
            fail_code = pfc_pkg::ST_TRAILING;
        end else if (phase_reg != pfc_pkg::PH_DRAIN) begin
            result.field_kind = pfc_pkg::phase_kind(phase_reg);
            if (phase_reg == pfc_pkg::PH_IDLEN || phase_reg == pfc_pkg::PH_ID) begin
                result.entry_index = entry_reg;
            end
            acc_next  = acc_shift;
            left_next = left_dec;
            if (left_dec == 16'd0) begin
                result.field_complete = 1'b1;
                result.field_value    = acc_shift;
                case (phase_reg)
                    pfc_pkg::PH_VER: begin
                        if (acc_shift[7:0] != cfg.version_code) begin
                            do_fail   = 1'b1;
                            fail_code = pfc_pkg::ST_BAD_VERSION;
                        end else begin
                            do_enter    = 1'b1;
                            enter_phase = pfc_pkg::PH_TYPE;
                        end
                    end
                    pfc_pkg::PH_TYPE: begin
                        if (acc_shift[7:0] == cfg.roster_type_code) begin
                            msg_next    = pfc_pkg::MSG_ROSTER;
                            do_enter    = 1'b1;
                            enter_phase = pfc_pkg::PH_OP;
                        end else if (acc_shift[7:0] == cfg.case_open_type_code) begin
                            msg_next    = pfc_pkg::MSG_CASE;
                            do_enter    = 1'b1;
                            enter_phase = pfc_pkg::PH_CIDLEN;
                        end else if (acc_shift[7:0] == cfg.result_type_code) begin
                            msg_next    = pfc_pkg::MSG_RESULT;
                            do_enter    = 1'b1;
                            enter_phase = pfc_pkg::PH_CIDLEN;
                        end else begin
                            do_fail   = 1'b1;
                            fail_code = pfc_pkg::ST_BAD_TYPE;
                        end
                    end
                    pfc_pkg::PH_OP: begin
                        if (acc_shift[7:0] != cfg.add_op_code &&
                            acc_shift[7:0] != cfg.remove_op_code) begin
                            do_fail   = 1'b1;
                            fail_code = pfc_pkg::ST_BAD_OP;
                        end else begin
                            do_enter    = 1'b1;
                            enter_phase = pfc_pkg::PH_COUNT;
                        end
                    end
                    pfc_pkg::PH_COUNT: begin
                        if (v16 == 16'd0 || v16 > 16'(pfc_pkg::MAX_ENTRIES) ||
                            v16 > {5'd0, cfg.entry_capacity}) begin
                            do_fail   = 1'b1;
                            fail_code = pfc_pkg::ST_BAD_COUNT;
                        end else begin
                            entries_next = v16[10:0];
                            entry_next   = 10'd0;
                            do_enter     = 1'b1;
                            enter_phase  = pfc_pkg::PH_IDLEN;
                        end
                    end
                    pfc_pkg::PH_CIDLEN, pfc_pkg::PH_IDLEN: begin
                        if (v16 == 16'd0 || v16 > cfg.max_id_length) begin
                            do_fail   = 1'b1;
                            fail_code = pfc_pkg::ST_BAD_LENGTH;
                        end else begin
                            do_enter    = 1'b1;
                            use_size    = 1'b1;
                            enter_size  = v16;
                            enter_phase = (phase_reg == pfc_pkg::PH_CIDLEN) ?
                                          pfc_pkg::PH_CID : pfc_pkg::PH_ID;
                        end
                    end
                    pfc_pkg::PH_CID: begin
                        do_enter    = 1'b1;
                        enter_phase = (msg_reg == pfc_pkg::MSG_CASE) ?
                                      pfc_pkg::PH_CUTOFF : pfc_pkg::PH_DRAW;
                    end
                    pfc_pkg::PH_CUTOFF: begin
                        do_enter    = 1'b1;
                        enter_phase = (msg_reg == pfc_pkg::MSG_CASE) ?
                                      pfc_pkg::PH_DRAW : pfc_pkg::PH_SEED;
                    end
                    pfc_pkg::PH_DRAW: begin
                        do_enter    = 1'b1;
                        enter_phase = (msg_reg == pfc_pkg::MSG_CASE) ?
                                      pfc_pkg::PH_PRIM : pfc_pkg::PH_CUTOFF;
                    end
                    pfc_pkg::PH_SEED: begin
                        do_enter    = 1'b1;
                        enter_phase = pfc_pkg::PH_ALGO;
                    end
                    pfc_pkg::PH_ALGO: begin
                        if (msg_reg == pfc_pkg::MSG_CASE) begin
                            phase_next = pfc_pkg::PH_DONE;
                        end else begin
                            do_enter    = 1'b1;
                            enter_phase = pfc_pkg::PH_PRIM;
                        end
                    end
                    pfc_pkg::PH_PRIM: begin
                        prim_next   = v32;
                        do_enter    = 1'b1;
                        enter_phase = pfc_pkg::PH_ALT;
                    end
                    pfc_pkg::PH_ALT: begin
                        if (msg_reg == pfc_pkg::MSG_CASE) begin
                            do_enter    = 1'b1;
                            enter_phase = pfc_pkg::PH_ALGO;
                        end else if (prim_reg > 32'(pfc_pkg::MAX_ENTRIES) ||
                                     v32 > alt_room) begin
                            do_fail   = 1'b1;
                            fail_code = pfc_pkg::ST_BAD_COUNT;
                        end else if (total == 16'd0 ||
                                     total > 16'(pfc_pkg::MAX_ENTRIES) ||
                                     total > {5'd0, cfg.entry_capacity}) begin
                            do_fail   = 1'b1;
                            fail_code = pfc_pkg::ST_BAD_COUNT;
                        end else begin
                            entries_next = total[10:0];
                            entry_next   = 10'd0;
                            do_enter     = 1'b1;
                            enter_phase  = pfc_pkg::PH_IDLEN;
                        end
                    end
                    pfc_pkg::PH_ID: begin
                        entry_next   = entry_reg + 10'd1;
                        entries_next = entries_dec;
                        if (entries_dec == 11'd0) begin
                            phase_next = pfc_pkg::PH_DONE;
                        end else begin
                            do_enter    = 1'b1;
                            enter_phase = pfc_pkg::PH_IDLEN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (do_enter) begin
            phase_next = enter_phase;
            left_next  = use_size ? enter_size : pfc_pkg::field_size(enter_phase);
            acc_next   = 64'd0;
        end
        if (do_fail) begin
            if (err_reg == pfc_pkg::ST_OK) begin
                err_next = fail_code;
            end
            phase_next = pfc_pkg::PH_DRAIN;
        end
        if (in_item.last_byte && err_next == pfc_pkg::ST_OK &&
            phase_next != pfc_pkg::PH_DONE) begin
            err_next = pfc_pkg::ST_TRUNCATED;
        end

        result.message_type = msg_next;
        result.message_end  = in_item.last_byte;
        result.status       = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_item.last_byte)) begin
            phase_reg   <= pfc_pkg::PH_VER;
            left_reg    <= 16'd1;
            acc_reg     <= 64'd0;
            msg_reg     <= pfc_pkg::MSG_UNKNOWN;
            entries_reg <= 11'd0;
            entry_reg   <= 10'd0;
            prim_reg    <= 32'd0;
            err_reg     <= pfc_pkg::ST_OK;
        end else if (advance) begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            acc_reg     <= acc_next;
            msg_reg     <= msg_next;
            entries_reg <= entries_next;
            entry_reg   <= entry_next;
            prim_reg    <= prim_next;
            err_reg     <= err_next;
        end
    end

endmodule

// ===== hw/rtl/payload_frame_checker.sv =====
// ----------------------------------------------------------------------------
// payload_frame_checker
// Byte-wise checker and labeler for length-prefixed messages.
// ----------------------------------------------------------------------------
// Each result is registered in the output stage, or the skid stage on a stall.
// Throughput: one item per cycle while s_ready is high (skid stage empty).
// A skid stage holds one extra result, so input stalls only after two
// results wait on the m_ side.
// Reset clears the parser to expect a version byte and loads register defaults.
module payload_frame_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pfc_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pfc_pkg::out_item_t  m_item,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);

    pfc_pkg::cfg_t      cfg_reg;
    pfc_pkg::out_item_t result;
    pfc_pkg::out_item_t out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               accept;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    pfc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (accept),
        .cfg     (cfg_reg),
        .in_item (s_item),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.version_code        <= 8'd1;
            cfg_reg.roster_type_code    <= 8'd1;
            cfg_reg.case_open_type_code <= 8'd2;
            cfg_reg.result_type_code    <= 8'd3;
            cfg_reg.add_op_code         <= 8'd1;
            cfg_reg.remove_op_code      <= 8'd2;
            cfg_reg.max_id_length       <= 16'd255;
            cfg_reg.entry_capacity      <= 11'd1024;
        end else if (cfg_we) begin
            case (cfg_index)
                pfc_pkg::REG_VERSION:   cfg_reg.version_code        <= cfg_wdata[7:0];
                pfc_pkg::REG_ROSTER:    cfg_reg.roster_type_code    <= cfg_wdata[7:0];
                pfc_pkg::REG_CASE_OPEN: cfg_reg.case_open_type_code <= cfg_wdata[7:0];
                pfc_pkg::REG_RESULT:    cfg_reg.result_type_code    <= cfg_wdata[7:0];
                pfc_pkg::REG_ADD_OP:    cfg_reg.add_op_code         <= cfg_wdata[7:0];
                pfc_pkg::REG_REMOVE_OP: cfg_reg.remove_op_code      <= cfg_wdata[7:0];
                pfc_pkg::REG_MAX_IDLEN: cfg_reg.max_id_length       <= cfg_wdata;
                pfc_pkg::REG_CAPACITY:  cfg_reg.entry_capacity      <= cfg_wdata[10:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= result;
            end
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while the output stage is empty");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("item taken during an output stall was not captured");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.field_kind <= pfc_pkg::KIND_IGNORED))
        else $error("field kind out of range");

    a_value_when_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.field_complete) |-> (out_reg.field_value == 64'd0))
        else $error("field value set on a byte that completes no field");

    a_ignored_incomplete: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.field_kind == pfc_pkg::KIND_IGNORED)
            |-> !out_reg.field_complete)
        else $error("ignored byte marked as field end");

endmodule
